// ===== rtl/scc_pkg.sv =====
`default_nettype none

package scc_pkg;

  // Time constants in game milliseconds.
  localparam logic [27:0] MsPerDay  = 28'd86400000;
  localparam logic [11:0] MsScale   = 12'd3600;

  // Calendar limits and reset values.
  localparam logic [13:0] YearMax     = 14'd9999;
  localparam logic [26:0] TodReset    = 27'd86340000;
  localparam logic [15:0] SpeedReset  = 16'd60;
  localparam logic [4:0]  DayReset    = 5'd31;
  localparam logic [3:0]  MonthReset  = 4'd3;
  localparam logic [13:0] YearReset   = 14'd2021;
  localparam logic [6:0]  CentReset   = 7'd20;
  localparam logic [6:0]  YyReset     = 7'd21;
  localparam logic [2:0]  WeekdayReset = 3'd3;
  localparam logic [2:0]  WeekdayLast = 3'd7;
  localparam logic [3:0]  MonthLast   = 4'd12;
  localparam logic [3:0]  MonthFeb    = 4'd2;
  localparam logic [6:0]  YyLast      = 7'd99;

  // Number of compare-subtract steps that split the time of day into
  // five hour bits, six minute bits and six second bits.
  localparam int ConvSteps = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic start;
    logic div_step;
    logic add;
    logic cal;
    logic conv_step;
    logic load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic speed_zero;
    logic div_last;
    logic conv_last;
  } dp_status_t;

  // Weight subtracted at each conversion step, highest hour bit first.
  function automatic logic [26:0] conv_weight(input logic [4:0] idx);
    logic [26:0] w;
    case (idx)
      5'd0:    w = 27'd57600000;
      5'd1:    w = 27'd28800000;
      5'd2:    w = 27'd14400000;
      5'd3:    w = 27'd7200000;
      5'd4:    w = 27'd3600000;
      5'd5:    w = 27'd1920000;
      5'd6:    w = 27'd960000;
      5'd7:    w = 27'd480000;
      5'd8:    w = 27'd240000;
      5'd9:    w = 27'd120000;
      5'd10:   w = 27'd60000;
      5'd11:   w = 27'd32000;
      5'd12:   w = 27'd16000;
      5'd13:   w = 27'd8000;
      5'd14:   w = 27'd4000;
      5'd15:   w = 27'd2000;
      5'd16:   w = 27'd1000;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

  // Length of a month, with February following the leap flag.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    case (month) inside
      MonthFeb:                    d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     d = 5'd30;
      default:                     d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scc_datapath.sv =====
`default_nettype none

module scc_datapath
  import scc_pkg::*;
#(
  parameter int DELTA_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_wdata,
  input  wire logic [DELTA_BITS-1:0] delta_ms,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  output logic [4:0]                 hour,
  output logic [5:0]                 minute,
  output logic [5:0]                 second,
  output logic [4:0]                 day,
  output logic [3:0]                 month,
  output logic [13:0]                year,
  output logic [2:0]                 weekday,
  output logic                       day_rolled
);

  // The scaled numerator needs 12 bits for the scale and one for the carry.
  localparam int NUM_W = DELTA_BITS + 13;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int CMP_W = (NUM_W > 28) ? NUM_W : 28;

  logic [15:0]           speed;
  logic [DELTA_BITS-1:0] delta_q;
  logic [NUM_W-1:0]      num;
  logic [15:0]           div_r;
  logic [CNT_W-1:0]      div_cnt;
  logic [15:0]           rem;
  logic [26:0]           tod;
  logic                  rolled;
  logic [4:0]            cur_day;
  logic [3:0]            cur_month;
  logic [13:0]           cur_year;
  logic [6:0]            cent;
  logic [6:0]            yy;
  logic [2:0]            cur_weekday;
  logic [26:0]           work;
  logic [4:0]            conv_cnt;
  logic [ConvSteps-1:0]  conv_bits;

  logic [16:0] r_shift;
  logic [16:0] r_diff;
  logic        r_ge;
  logic        clamp;
  logic [27:0] adv;
  logic [27:0] total;
  logic        total_wrap;
  logic [27:0] total_sub;
  logic        leap;
  logic [4:0]  dim;
  logic [26:0] weight;
  logic        w_ge;

  // Speed register; user writes only while the block is idle (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= SpeedReset;
    end else if (cfg_we) begin
      speed <= cfg_wdata;
    end
  end

  // One quotient bit per cycle of the restoring divider.
  assign r_shift = {div_r, num[NUM_W-1]};
  assign r_diff  = r_shift - {1'b0, speed};
  assign r_ge    = (r_shift >= {1'b0, speed});

  // Clamp the advance to one day and add it to the time of day.
  assign clamp      = (CMP_W'(num) > CMP_W'(MsPerDay));
  assign adv        = clamp ? MsPerDay : 28'(num);
  assign total      = {1'b0, tod} + adv;
  assign total_wrap = (total >= MsPerDay);
  assign total_sub  = total - MsPerDay;

  // Leap year from the two-digit year and the century.
  assign leap = ((yy[1:0] == 2'd0) && (yy != 7'd0)) ||
                ((yy == 7'd0) && (cent[1:0] == 2'd0));
  assign dim  = month_days(cur_month, leap);

  // Time-of-day split by compare-subtract against fixed weights.
  assign weight = conv_weight(conv_cnt);
  assign w_ge   = (work >= weight);

  assign status.speed_zero = (speed == 16'd0);
  assign status.div_last   = (div_cnt == '0);
  assign status.conv_last  = (conv_cnt == 5'(ConvSteps - 1));

  // Work registers of the divider and the conversion.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      delta_q <= delta_ms;
    end
    if (cmd.start) begin
      num     <= NUM_W'(delta_q) * NUM_W'(MsScale) + NUM_W'(rem);
      div_r   <= 16'd0;
      div_cnt <= CNT_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      num     <= {num[NUM_W-2:0], r_ge};
      div_r   <= r_ge ? r_diff[15:0] : r_shift[15:0];
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.cal) begin
      work     <= tod;
      conv_cnt <= 5'd0;
    end else if (cmd.conv_step) begin
      work      <= w_ge ? (work - weight) : work;
      conv_bits <= {conv_bits[ConvSteps-2:0], w_ge};
      conv_cnt  <= conv_cnt + 1'b1;
    end
  end

  // Clock and calendar state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem         <= 16'd0;
      tod         <= TodReset;
      rolled      <= 1'b0;
      cur_day     <= DayReset;
      cur_month   <= MonthReset;
      cur_year    <= YearReset;
      cent        <= CentReset;
      yy          <= YyReset;
      cur_weekday <= WeekdayReset;
    end else begin
      if (cmd.start) begin
        rolled <= 1'b0;
      end
      if (cmd.add) begin
        rem    <= div_r;
        tod    <= total_wrap ? total_sub[26:0] : total[26:0];
        rolled <= total_wrap;
      end
      // Advance the date by one day after a midnight crossing.
      if (cmd.cal && rolled) begin
        cur_weekday <= (cur_weekday >= WeekdayLast) ? 3'd1 : cur_weekday + 3'd1;
        if (cur_day >= dim) begin
          cur_day <= 5'd1;
          if (cur_month >= MonthLast) begin
            cur_month <= 4'd1;
            if (cur_year < YearMax) begin
              cur_year <= cur_year + 14'd1;
              if (yy == YyLast) begin
                yy   <= 7'd0;
                cent <= cent + 7'd1;
              end else begin
                yy <= yy + 7'd1;
              end
            end
          end else begin
            cur_month <= cur_month + 4'd1;
          end
        end else begin
          cur_day <= cur_day + 5'd1;
        end
      end
    end
  end

  // Output register, loaded when the result slot is free.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hour       <= conv_bits[16:12];
      minute     <= conv_bits[11:6];
      second     <= conv_bits[5:0];
      day        <= cur_day;
      month      <= cur_month;
      year       <= cur_year;
      weekday    <= cur_weekday;
      day_rolled <= rolled;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_speed: assert property (@(posedge clk) disable iff (rst)
    cmd.add |=> (rem < speed))
    else $error("carried remainder not below speed");

  a_tod_in_day: assert property (@(posedge clk) disable iff (rst)
    {1'b0, tod} < MsPerDay)
    else $error("time of day out of range");

  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    (cur_day != 5'd0) && (cur_month != 4'd0) && (cur_month <= MonthLast) &&
    (cur_weekday != 3'd0) && (cur_year <= YearMax))
    else $error("calendar state out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/scc_ctrl.sv =====
`default_nettype none

module scc_ctrl
  import scc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StMul  = 7'b0000010,
    StDiv  = 7'b0000100,
    StAdd  = 7'b0001000,
    StCal  = 7'b0010000,
    StConv = 7'b0100000,
    StLoad = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == StIdle);

  // Sequence one request through scale, divide, add, date and conversion.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = StMul;
        end
      end
      StMul: begin
        cmd.start  = 1'b1;
        state_next = status.speed_zero ? StCal : StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = StAdd;
        end
      end
      StAdd: begin
        cmd.add    = 1'b1;
        state_next = StCal;
      end
      StCal: begin
        cmd.cal    = 1'b1;
        state_next = StConv;
      end
      StConv: begin
        cmd.conv_step = 1'b1;
        if (status.conv_last) begin
          state_next = StLoad;
        end
      end
      StLoad: begin
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting result");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == StMul))
    else $error("accepted request did not start processing");

  a_idle_no_work: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.div_step || cmd.add || cmd.cal || cmd.conv_step || cmd.load))
    else $error("datapath command while idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/scaled_calendar_clock.sv =====
// Scaled calendar clock.
//
// Input channel (in_valid/in_ready, delta_ms): each request is a tick that
// carries real milliseconds since the previous tick. Output channel
// (out_valid/out_ready): one result per tick with hour, minute, second,
// day, month, year, weekday and day_rolled. The user must write the speed
// register through cfg_we/cfg_wdata only while no request is in flight;
// the block itself does not enforce this. A speed of zero pauses time.
//
// One request is processed at a time: the next tick is accepted only after
// the result of the previous one is loaded into the output register. The
// serial restoring divider by the speed register produces one quotient bit
// per cycle over DELTA_BITS + 13 bits, and the time-of-day split into hours,
// minutes and seconds takes 17 compare-subtract steps. A paused tick skips
// the divider.
//
// The result sits in an output register, so a new tick is accepted while
// the previous result waits. If the receiver still stalls when the next
// result is ready, the block holds it and stops accepting ticks.
// Synchronous reset sets 23:59:00 on 31 March 2021, weekday 3, speed 60.

`default_nettype none

module scaled_calendar_clock
  import scc_pkg::*;
#(
  parameter int DELTA_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DELTA_BITS-1:0] delta_ms,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [4:0]                 hour,
  output logic [5:0]                 minute,
  output logic [5:0]                 second,
  output logic [4:0]                 day,
  output logic [3:0]                 month,
  output logic [13:0]                year,
  output logic [2:0]                 weekday,
  output logic                       day_rolled
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Controller sequencing each request.
  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Divider, clock, calendar and output register.
  scc_datapath #(
    .DELTA_BITS (DELTA_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .delta_ms   (delta_ms),
    .cmd        (cmd),
    .status     (status),
    .hour       (hour),
    .minute     (minute),
    .second     (second),
    .day        (day),
    .month      (month),
    .year       (year),
    .weekday    (weekday),
    .day_rolled (day_rolled)
  );

endmodule

`default_nettype wire

// ===== tb/scaled_calendar_clock_checker.sv =====
`timescale 1ns / 100ps

module scaled_calendar_clock_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [15:0] delta_ms,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [5:0]  second,
  input  wire logic [4:0]  day,
  input  wire logic [3:0]  month,
  input  wire logic [13:0] year,
  input  wire logic [2:0]  weekday,
  input  wire logic        day_rolled,
  output int               error_count,
  output int               pending
);

  localparam int unsigned DayMs       = 86400000;
  localparam int unsigned HourMs      = 3600000;
  localparam int unsigned MinuteMs    = 60000;
  localparam int unsigned SecondMs    = 1000;
  localparam int unsigned GameScale   = 3600;
  localparam int unsigned LastYear    = 9999;
  localparam int unsigned LastMonth   = 12;
  localparam int unsigned LastWeekday = 7;
  localparam int unsigned ResetTod    = 86340000;
  localparam logic [15:0] ResetRate   = 16'd60;
  localparam int          ReportLimit = 10;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        rolled;
  } clock_reading_t;

  // Shadow copy of the clock state and the speed register.
  logic [15:0]    rate;
  int unsigned    tod_ms;
  int unsigned    carry_rem;
  int unsigned    cal_day;
  int unsigned    cal_month;
  int unsigned    cal_year;
  int unsigned    cal_weekday;
  clock_reading_t expected_readings[$];
  clock_reading_t got;
  clock_reading_t want;

  // Applies one tick to the shadow state and returns the reading it produces.
  function automatic clock_reading_t advance_clock(input logic [15:0] d);
    longint unsigned num;
    longint unsigned adv;
    longint unsigned total;
    int unsigned     month_len;
    logic            leap;
    logic            rolled;
    clock_reading_t  r;
    rolled = 1'b0;
    if (rate != 0) begin
      num = d;
      num = num * GameScale + carry_rem;
      adv = num / rate;
      carry_rem = 32'(num % rate);
      // At most one midnight can pass per tick.
      if (adv > DayMs) adv = DayMs;
      total = tod_ms + adv;
      if (total >= DayMs) begin
        total = total - DayMs;
        rolled = 1'b1;
      end
      tod_ms = 32'(total);
      if (rolled) begin
        leap = ((cal_year % 4 == 0) && (cal_year % 100 != 0)) || (cal_year % 400 == 0);
        case (cal_month)
          2:           month_len = leap ? 29 : 28;
          4, 6, 9, 11: month_len = 30;
          default:     month_len = 31;
        endcase
        cal_weekday = (cal_weekday >= LastWeekday) ? 1 : cal_weekday + 1;
        cal_day = cal_day + 1;
        if (cal_day > month_len) begin
          cal_day = 1;
          cal_month = cal_month + 1;
        end
        // The year stops at its last value; the date still wraps to January.
        if (cal_month > LastMonth) begin
          cal_month = 1;
          if (cal_year < LastYear) cal_year = cal_year + 1;
        end
      end
    end
    r.hour    = 5'(tod_ms / HourMs);
    r.minute  = 6'((tod_ms / MinuteMs) % 60);
    r.second  = 6'((tod_ms / SecondMs) % 60);
    r.day     = 5'(cal_day);
    r.month   = 4'(cal_month);
    r.year    = 14'(cal_year);
    r.weekday = 3'(cal_weekday);
    r.rolled  = rolled;
    return r;
  endfunction

  // Results are retired before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      rate = ResetRate;
      tod_ms = ResetTod;
      carry_rem = 0;
      cal_day = 31;
      cal_month = 3;
      cal_year = 2021;
      cal_weekday = 3;
      expected_readings.delete();
      error_count = 0;
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {hour, minute, second, day, month, year, weekday, day_rolled};
        if (expected_readings.size() == 0) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("%t: result with no request outstanding: %0d:%0d:%0d %0d/%0d/%0d",
                     $time, got.hour, got.minute, got.second, got.day, got.month,
                     got.year);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= ReportLimit)
              $display({"%t: reading mismatch: expected %0d:%0d:%0d %0d/%0d/%0d wd %0d ",
                        "rolled %0d, got %0d:%0d:%0d %0d/%0d/%0d wd %0d rolled %0d"},
                       $time, want.hour, want.minute, want.second, want.day, want.month,
                       want.year, want.weekday, want.rolled, got.hour, got.minute,
                       got.second, got.day, got.month, got.year, got.weekday,
                       got.rolled);
          end
        end
      end
      if (in_valid && in_ready) expected_readings.push_back(advance_clock(delta_ms));
      if (cfg_we) rate = cfg_wdata;
      pending = expected_readings.size();
    end
  end

endmodule

// ===== tb/scaled_calendar_clock_tb.sv =====
`timescale 1ns / 100ps

module scaled_calendar_clock_tb;

  localparam int RandomTicks  = 1300;
  localparam int StallLimit   = 5000;
  localparam int SettleCycles = 60;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] delta_ms;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [2:0]  weekday;
  logic        day_rolled;
  int          error_count;
  int          pending;
  logic        steady = 1'b0;
  int          ticks_sent;
  int          stall_cycles;

  scaled_calendar_clock #(
    .DELTA_BITS(16)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .delta_ms  (delta_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hour      (hour),
    .minute    (minute),
    .second    (second),
    .day       (day),
    .month     (month),
    .year      (year),
    .weekday   (weekday),
    .day_rolled(day_rolled)
  );

  scaled_calendar_clock_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .delta_ms   (delta_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hour       (hour),
    .minute     (minute),
    .second     (second),
    .day        (day),
    .month      (month),
    .year       (year),
    .weekday    (weekday),
    .day_rolled (day_rolled),
    .error_count(error_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls about 30 percent of the time, except in the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  // Sends one tick request, with random idle cycles ahead of it.
  task automatic send_tick(input logic [15:0] d);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    delta_ms <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Writes the speed register once the block has drained.
  task automatic set_speed(input logic [15:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Ends the run when nothing has moved for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("scaled_calendar_clock_tb failed");
    $finish;
  end

  initial begin
    int          phase_len;
    logic [15:0] rate;
    logic [15:0] d;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    in_valid = 1'b0;
    delta_ms = 16'd0;
    ticks_sent = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // At the reset speed one real second is one game minute: land exactly on midnight.
    send_tick(16'd1000);
    send_tick(16'd0);
    send_tick(16'd1);
    send_tick(16'hFFFF);
    // An odd speed leaves a remainder that must carry across ticks.
    set_speed(16'd7);
    send_tick(16'd1);
    send_tick(16'd1);
    send_tick(16'd1);
    send_tick(16'd3);
    // Paused clock.
    set_speed(16'd0);
    send_tick(16'hFFFF);
    send_tick(16'd0);
    // Fastest speed: advances beyond one day are clamped.
    set_speed(16'd1);
    send_tick(16'hFFFF);
    send_tick(16'd24000);
    send_tick(16'd23999);
    send_tick(16'd0);
    // Slowest speed builds a large remainder, which then meets a small speed.
    set_speed(16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'd1);
    send_tick(16'd18);
    set_speed(16'd2);
    send_tick(16'd5);
    send_tick(16'h5555);
    send_tick(16'hAAAA);

    // Random phases; fast speeds dominate so that the calendar covers years.
    while (ticks_sent < RandomTicks) begin
      case ($urandom_range(9))
        0, 1, 2, 3: rate = 16'($urandom_range(4, 1));
        4:          rate = 16'd0;
        5:          rate = 16'hFFFF;
        6:          rate = 16'($urandom_range(65535, 1));
        7:          rate = 16'd60;
        8:          rate = 16'($urandom_range(200, 5));
        default:    rate = 16'd3600;
      endcase
      set_speed(rate);
      phase_len = int'($urandom_range(60, 10));
      repeat (phase_len) begin
        case ($urandom_range(9))
          0, 1:    d = 16'($urandom_range(100));
          2:       d = 16'hFFFF;
          3:       d = 16'd0;
          4:       d = 16'($urandom_range(25000, 23000));
          default: d = 16'($urandom_range(65535));
        endcase
        steady <= (ticks_sent >= 500) && (ticks_sent < 700);
        send_tick(d);
        ticks_sent++;
      end
    end
    steady <= 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (error_count == 0 && pending == 0)
      $display("scaled_calendar_clock_tb passed");
    else
      $display("scaled_calendar_clock_tb failed");
    $finish;
  end

endmodule
